// ----- rtl/pv_pkg.sv -----
// Shared widths, limits and the run summary type for the population variance block.
package pv_pkg;

  localparam int SAMPLE_W    = 16;
  localparam int MAX_SAMPLES = 65536;
  localparam int FRAC_BITS   = 8;

  localparam int CNT_W  = 17;
  localparam int SUM_W  = 33;
  localparam int SQS_W  = 47;
  localparam int VAR_W  = 39;
  localparam int SQ_W   = 2 * SAMPLE_W;

  // sum-of-squares is split into two halves for the shared multiplier
  localparam int SQ_LO_W = 24;
  localparam int SQ_HI_W = SQS_W - SQ_LO_W;

  localparam int MAG_W  = SUM_W - 1;
  localparam int MUL_W  = 32;
  localparam int PROD_W = 2 * MUL_W;
  localparam int NUM_W  = PROD_W;
  localparam int N2_W   = 2 * CNT_W;
  localparam int REM_W  = N2_W + 1;
  localparam int DIVD_W = NUM_W + FRAC_BITS;
  localparam int DCNT_W = $clog2(DIVD_W);

  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic [CNT_W-1:0]        count;
    logic signed [SUM_W-1:0] sum;
    logic [SQS_W-1:0]        sqsum;
    logic                    ovf;
  } run_t;

endpackage

// ----- rtl/pv_if.sv -----
// Valid/ready channel interfaces for samples in and variance results out.
interface pv_in_if;
  import pv_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;
  logic                       last;

  modport source  (output valid, output sample, output last, input ready);
  modport sink    (input valid, input sample, input last, output ready);
  modport monitor (input valid, input sample, input last, input ready);
endinterface

interface pv_out_if;
  import pv_pkg::*;
  logic             valid;
  logic             ready;
  logic [VAR_W-1:0] variance_scaled;
  logic [CNT_W-1:0] sample_total;
  logic             overflow;

  modport source  (output valid, output variance_scaled, output sample_total,
                   output overflow, input ready);
  modport sink    (input valid, input variance_scaled, input sample_total,
                   input overflow, output ready);
  modport monitor (input valid, input variance_scaled, input sample_total,
                   input overflow, input ready);
endinterface

// ----- rtl/pv_front.sv -----
// Front end: squares each sample, accumulates count, sum and sum of squares per run.
module pv_front (
  input  logic         clk,
  input  logic         rst_n,
  pv_in_if.sink        in_chan,
  output pv_pkg::run_t run_data,
  output logic         run_push,
  input  logic         run_full
);
  import pv_pkg::*;

  logic                       s1_valid_r;
  logic                       s1_last_r;
  logic signed [SAMPLE_W-1:0] s1_sample_r;
  logic [SQ_W-1:0]            s1_sq_r;

  logic [CNT_W-1:0]        count_r;
  logic signed [SUM_W-1:0] sum_r;
  logic [SQS_W-1:0]        sqsum_r;
  logic                    ovf_r;

  logic signed [SQ_W-1:0] sq_full;
  logic                   s2_fire;
  logic                   in_ready;
  logic                   sat;
  run_t                   upd;

  assign sq_full  = in_chan.sample * in_chan.sample;
  assign s2_fire  = s1_valid_r && (!s1_last_r || !run_full);
  assign in_ready = !s1_valid_r || s2_fire;
  assign in_chan.ready = in_ready;

  // a full run drops further samples and marks overflow
  assign sat = (count_r == CNT_W'(MAX_SAMPLES));

  always_comb begin
    upd.ovf = ovf_r | sat;
    if (sat) begin
      upd.count = count_r;
      upd.sum   = sum_r;
      upd.sqsum = sqsum_r;
    end else begin
      upd.count = count_r + CNT_W'(1);
      upd.sum   = sum_r + {{(SUM_W-SAMPLE_W){s1_sample_r[SAMPLE_W-1]}}, s1_sample_r};
      upd.sqsum = sqsum_r + {{(SQS_W-SQ_W){1'b0}}, s1_sq_r};
    end
  end

  assign run_data = upd;
  assign run_push = s1_valid_r && s1_last_r && !run_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      count_r    <= '0;
      sum_r      <= '0;
      sqsum_r    <= '0;
      ovf_r      <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_chan.valid;
      end
      if (in_ready && in_chan.valid) begin
        s1_last_r   <= in_chan.last;
        s1_sample_r <= in_chan.sample;
        s1_sq_r     <= SQ_W'(sq_full);
      end
      if (s2_fire) begin
        if (s1_last_r) begin
          count_r <= '0;
          sum_r   <= '0;
          sqsum_r <= '0;
          ovf_r   <= 1'b0;
        end else begin
          count_r <= upd.count;
          sum_r   <= upd.sum;
          sqsum_r <= upd.sqsum;
          ovf_r   <= upd.ovf;
        end
      end
    end
  end

endmodule

// ----- rtl/pv_queue.sv -----
// Short queue of finished run summaries between the front and back ends.
module pv_queue (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  pv_pkg::run_t push_data,
  output logic         full,
  input  logic         pop,
  output pv_pkg::run_t pop_data,
  output logic         empty
);
  import pv_pkg::*;

  run_t              mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] fill_r;
  logic              do_push;
  logic              do_pop;

  assign full     = (fill_r == QCNT_W'(QDEPTH));
  assign empty    = (fill_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        fill_r <= fill_r + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        fill_r <= fill_r - QCNT_W'(1);
      end
    end
  end

endmodule

// ----- rtl/pv_back.sv -----
// Back end: forms n*sumsq - sum^2 and n^2 on a shared multiplier, then divides bit-serially.
module pv_back (
  input  logic         clk,
  input  logic         rst_n,
  input  pv_pkg::run_t run_data,
  input  logic         run_avail,
  output logic         run_pop,
  pv_out_if.source     out_chan
);
  import pv_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_M0, S_M1, S_M2, S_M3, S_LOAD, S_DIV, S_OUT
  } state_t;

  state_t state_r;

  logic [CNT_W-1:0]  n_r;
  logic [SQS_W-1:0]  sqsum_r;
  logic [MAG_W-1:0]  smag_r;
  logic              ovf_r;
  logic [PROD_W-1:0] prod_r;
  logic [NUM_W-1:0]  lhs_r;
  logic [NUM_W-1:0]  rhs_r;
  logic [N2_W-1:0]   n2_r;
  logic [REM_W-1:0]  rem_r;
  logic [DIVD_W-1:0] dq_r;
  logic [DCNT_W-1:0] dcnt_r;
  logic [VAR_W-1:0]  var_r;
  logic [CNT_W-1:0]  total_r;
  logic              oflag_r;

  logic [MUL_W-1:0]   mul_a;
  logic [MUL_W-1:0]   mul_b;
  logic [SUM_W-1:0]   sum_neg;
  logic [REM_W-1:0]   rem_shift;
  logic               ge;
  logic [REM_W-1:0]   rem_nxt;
  logic [DIVD_W-1:0]  dq_nxt;

  assign sum_neg = -run_data.sum;

  always_comb begin
    unique case (state_r)
      S_M0: begin
        mul_a = MUL_W'(n_r);
        mul_b = MUL_W'(sqsum_r[SQ_LO_W-1:0]);
      end
      S_M1: begin
        mul_a = MUL_W'(n_r);
        mul_b = MUL_W'(sqsum_r[SQS_W-1:SQ_LO_W]);
      end
      S_M2: begin
        mul_a = MUL_W'(smag_r);
        mul_b = MUL_W'(smag_r);
      end
      default: begin
        mul_a = MUL_W'(n_r);
        mul_b = MUL_W'(n_r);
      end
    endcase
  end

  assign rem_shift = {rem_r[REM_W-2:0], dq_r[DIVD_W-1]};
  assign ge        = (rem_shift >= {1'b0, n2_r});
  assign rem_nxt   = ge ? (rem_shift - {1'b0, n2_r}) : rem_shift;
  assign dq_nxt    = {dq_r[DIVD_W-2:0], ge};

  assign run_pop = (state_r == S_IDLE) && run_avail;

  assign out_chan.valid           = (state_r == S_OUT);
  assign out_chan.variance_scaled = var_r;
  assign out_chan.sample_total    = total_r;
  assign out_chan.overflow        = oflag_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      prod_r <= mul_a * mul_b;
      unique case (state_r)
        S_IDLE: begin
          if (run_avail) begin
            n_r     <= run_data.count;
            sqsum_r <= run_data.sqsum;
            ovf_r   <= run_data.ovf;
            smag_r  <= run_data.sum[SUM_W-1] ? sum_neg[MAG_W-1:0]
                                             : run_data.sum[MAG_W-1:0];
            state_r <= S_M0;
          end
        end
        S_M0: begin
          state_r <= S_M1;
        end
        S_M1: begin
          lhs_r   <= prod_r;
          state_r <= S_M2;
        end
        S_M2: begin
          lhs_r   <= lhs_r + {prod_r[NUM_W-SQ_LO_W-1:0], {SQ_LO_W{1'b0}}};
          state_r <= S_M3;
        end
        S_M3: begin
          rhs_r   <= prod_r;
          state_r <= S_LOAD;
        end
        S_LOAD: begin
          n2_r   <= prod_r[N2_W-1:0];
          rem_r  <= '0;
          dcnt_r <= DCNT_W'(DIVD_W - 1);
          // negative or zero spread clamps to zero
          if (lhs_r > rhs_r) begin
            dq_r <= {lhs_r - rhs_r, {FRAC_BITS{1'b0}}};
          end else begin
            dq_r <= '0;
          end
          state_r <= S_DIV;
        end
        S_DIV: begin
          rem_r  <= rem_nxt;
          dq_r   <= dq_nxt;
          dcnt_r <= dcnt_r - DCNT_W'(1);
          if (dcnt_r == '0) begin
            var_r   <= dq_nxt[VAR_W-1:0];
            total_r <= n_r;
            oflag_r <= ovf_r;
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_chan.ready) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- rtl/population_variance.sv -----
// Top level of the population variance block: front end, run queue and divider back end.
//
//  channel   | dir | handshake     | payload
//  ----------+-----+---------------+------------------------------------------
//  in_chan   | in  | valid / ready | sample (s16), last
//  out_chan  | out | valid / ready | variance_scaled (u39), sample_total, overflow
//
// Samples transfer at one per cycle; a two-stage front (square, accumulate) keeps up.
// Each run's result is formed in the back end by four passes of the shared 32x32 multiplier
// and a restoring divider that resolves one quotient bit per cycle.
// The front stalls only on a last sample when both queue entries are taken.
// Reset is synchronous, active low, and clears the accumulators, queue and sequencer.
module population_variance (
  input  logic     clk,
  input  logic     rst_n,
  pv_in_if.sink    in_chan,
  pv_out_if.source out_chan
);
  import pv_pkg::*;

  run_t front_run;
  run_t back_run;
  logic front_push;
  logic q_full;
  logic q_empty;
  logic back_pop;

  pv_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .run_data (front_run),
    .run_push (front_push),
    .run_full (q_full)
  );

  pv_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (front_push),
    .push_data (front_run),
    .full      (q_full),
    .pop       (back_pop),
    .pop_data  (back_run),
    .empty     (q_empty)
  );

  pv_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .run_data  (back_run),
    .run_avail (!q_empty),
    .run_pop   (back_pop),
    .out_chan  (out_chan)
  );

endmodule

// ----- rtl/pv_checker.sv -----
// Port-level checks on the population variance block and their binding.
module pv_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       in_last,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [pv_pkg::VAR_W-1:0]   out_variance_scaled,
  input logic [pv_pkg::CNT_W-1:0]   out_sample_total,
  input logic                       out_overflow
);
  import pv_pkg::*;

  logic in_seen;
  assign in_seen = in_valid && in_ready;

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid
      && $stable(out_variance_scaled) && $stable(out_sample_total)
      && $stable(out_overflow)))
    else $error("stalled result changed");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_sample_total != '0
      && out_sample_total <= CNT_W'(MAX_SAMPLES)))
    else $error("sample_total out of range");

  a_ovf_sat: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_overflow)
      |-> (out_sample_total == CNT_W'(MAX_SAMPLES)))
    else $error("overflow without saturated count");

  a_in_known: assert property (@(posedge clk) disable iff (!rst_n)
    in_seen |-> !$isunknown(in_last))
    else $error("transfer with unknown last flag");

endmodule

bind population_variance pv_checker u_pv_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .in_valid            (in_chan.valid),
  .in_ready            (in_chan.ready),
  .in_last             (in_chan.last),
  .out_valid           (out_chan.valid),
  .out_ready           (out_chan.ready),
  .out_variance_scaled (out_chan.variance_scaled),
  .out_sample_total    (out_chan.sample_total),
  .out_overflow        (out_chan.overflow)
);
